@@ hw/rtl/ljd_pkg.sv @@
// Shared constants for the layer neuron job dispatcher.
package ljd_pkg;

  // Operation codes carried by the op field of an input item.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // Field widths fixed by the item format.
  localparam int OP_W      = 2;
  localparam int BUSY_W    = 5;
  localparam int LIDX_W    = 3;
  localparam int SIZE_W    = 11;
  localparam int UNIT_W    = 3;
  localparam int NEURON_W  = 10;
  localparam int WEIGHT_W  = 23;
  localparam int ACT_W     = 14;
  localparam int LCOUNT_W  = 4;

  // Largest layer size kept in the size table; larger loads are clamped.
  localparam logic [SIZE_W-1:0] MAX_LAYER_SIZE = 11'd1024;

  // Highest neuron index; a layer ends there at the latest.
  localparam logic [NEURON_W-1:0] NEURON_LIMIT = '1;

  // The table never holds more than eight layers.
  localparam int TABLE_CAP = 8;

endpackage

@@ hw/rtl/layer_neuron_job_dispatcher_top.sv @@
// Layer neuron job dispatcher: hands neuron jobs to idle compute units.
// Latency: a job result is offered in the cycle after the tick item that causes it.
// Throughput: one input item per cycle while no results are pending; a tick yields up
// to min(NUM_UNITS, 5) results, delivered one per cycle while out_ready is high, and
// the next item is taken in the cycle the last of them is taken.
// Reset (rst, synchronous, active high) clears the run state, pending results and
// layer_count; the size table is not cleared and must be loaded before use.
module layer_neuron_job_dispatcher_top
  import ljd_pkg::*;
#(
  parameter int NUM_UNITS  = 5,
  parameter int MAX_LAYERS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [LCOUNT_W-1:0]  cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      op,
  input  logic [BUSY_W-1:0]    busy_mask,
  input  logic [LIDX_W-1:0]    layer_index,
  input  logic [SIZE_W-1:0]    layer_size,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [UNIT_W-1:0]    unit,
  output logic [SIZE_W-1:0]    input_size,
  output logic [NEURON_W-1:0]  neuron_index,
  output logic [WEIGHT_W-1:0]  weight_offset,
  output logic [ACT_W-1:0]     activation_offset,
  output logic                 done_res,
  output logic                 last
);

  // Units that actually have a busy bit, and the size table geometry.
  localparam int UNITS = (NUM_UNITS < BUSY_W) ? NUM_UNITS : BUSY_W;
  localparam int SEL_W = (UNITS > 1) ? $clog2(UNITS) : 1;
  localparam int DEPTH = (MAX_LAYERS < TABLE_CAP) ? MAX_LAYERS : TABLE_CAP;
  localparam int TIDX_W = $clog2(DEPTH);
  localparam logic [LCOUNT_W-1:0] DEPTH_L = LCOUNT_W'(DEPTH);

  // Configuration and run state.
  logic [LCOUNT_W-1:0] layer_count;
  logic [SIZE_W-1:0]   size_table [DEPTH];
  logic [LIDX_W-1:0]   layer_pos;
  logic [NEURON_W-1:0] neuron_pos;
  logic [WEIGHT_W-1:0] weight_ptr;
  logic [ACT_W-1:0]    activation_ptr;
  logic                running;
  logic [SIZE_W-1:0]   cur_isz;
  logic [SIZE_W-1:0]   cur_osz;

  // Result buffer: one slot per unit, shared fields kept once per tick.
  logic [UNITS-1:0]    pending;
  logic [NEURON_W-1:0] slot_np [UNITS];
  logic [WEIGHT_W-1:0] slot_wp [UNITS];
  logic [SIZE_W-1:0]   res_isz;
  logic [ACT_W-1:0]    res_act;
  logic                res_done;

  // Tick datapath signals.
  logic                in_fire;
  logic                out_fire;
  logic [LCOUNT_W-1:0] n_eff;
  logic [UNITS-1:0]    busy;
  logic                tick_go;
  logic [UNITS-1:0]    disp_mask;
  logic [NEURON_W-1:0] slot_np_next [UNITS];
  logic [WEIGHT_W-1:0] slot_wp_next [UNITS];
  logic [NEURON_W-1:0] np_end;
  logic [WEIGHT_W-1:0] wp_end;
  logic                layer_end;
  logic                finish;
  logic [LCOUNT_W-1:0] adv_idx;
  logic [SIZE_W-1:0]   adv_osz;
  logic [SIZE_W-1:0]   load_size;
  logic                load_ok;
  logic [UNITS-1:0]    pending_rest;
  logic [SEL_W-1:0]    sel;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Effective layer count: bounded by the table depth.
  assign n_eff = (layer_count > DEPTH_L) ? DEPTH_L : layer_count;
  assign busy  = busy_mask[UNITS-1:0];

  // A tick dispatches only while running; a layer's first neuron needs all units idle.
  assign tick_go = in_fire && (op == OP_TICK) && running && (n_eff >= LCOUNT_W'(2)) &&
                   !((neuron_pos == '0) && (busy != '0));

  // Walk the units in ascending order; the layer cannot change inside one tick,
  // so every dispatch uses the same input and output layer sizes.
  always_comb begin
    logic [NEURON_W-1:0] np_c;
    logic [WEIGHT_W-1:0] wp_c;
    logic                act_c;
    logic                end_c;
    np_c = neuron_pos;
    wp_c = weight_ptr;
    act_c = tick_go;
    end_c = 1'b0;
    disp_mask = '0;
    for (int u = 0; u < UNITS; u++) begin
      slot_np_next[u] = np_c;
      slot_wp_next[u] = wp_c;
      if (act_c && !busy[u]) begin
        disp_mask[u] = 1'b1;
        wp_c = wp_c + WEIGHT_W'(cur_isz);
        if (({1'b0, np_c} + SIZE_W'(1) >= cur_osz) || (np_c == NEURON_LIMIT)) begin
          act_c = 1'b0;
          end_c = 1'b1;
        end else begin
          np_c = np_c + NEURON_W'(1);
        end
      end
    end
    np_end = np_c;
    wp_end = wp_c;
    layer_end = end_c;
  end

  assign finish = layer_end && ((LCOUNT_W'(layer_pos) + LCOUNT_W'(2)) >= n_eff);

  // Size two table entries past the current layer (the next layer's output size), read when a layer completes.
  assign adv_idx = LCOUNT_W'(layer_pos) + LCOUNT_W'(2);
  assign adv_osz = (adv_idx < DEPTH_L) ? size_table[adv_idx[TIDX_W-1:0]] : '0;

  // Clamp a loaded size into one to the largest layer size.
  always_comb begin
    if (layer_size == '0) begin
      load_size = SIZE_W'(1);
    end else if (layer_size > MAX_LAYER_SIZE) begin
      load_size = MAX_LAYER_SIZE;
    end else begin
      load_size = layer_size;
    end
  end
  assign load_ok = in_fire && (op == OP_LOAD) && (LCOUNT_W'(layer_index) < DEPTH_L);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count <= '0;
    end else if (cfg_wr_en) begin
      layer_count <= cfg_wr_data;
    end
  end

  // Size table writes.
  always_ff @(posedge clk) begin
    if (load_ok) begin
      size_table[layer_index[TIDX_W-1:0]] <= load_size;
    end
  end

  // Current layer sizes: refreshed on start, on a layer change and by loads.
  always_ff @(posedge clk) begin
    if (in_fire && (op == OP_START)) begin
      cur_isz <= size_table[TIDX_W'(0)];
      cur_osz <= size_table[TIDX_W'(1)];
    end else if (load_ok) begin
      if (layer_index == layer_pos) begin
        cur_isz <= load_size;
      end
      if (LCOUNT_W'(layer_index) == LCOUNT_W'(layer_pos) + LCOUNT_W'(1)) begin
        cur_osz <= load_size;
      end
    end else if (layer_end && !finish) begin
      cur_isz <= cur_osz;
      cur_osz <= adv_osz;
    end
  end

  // Run state: positions, pointers and the running flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      layer_pos      <= '0;
      neuron_pos     <= '0;
      weight_ptr     <= '0;
      activation_ptr <= '0;
      running        <= 1'b0;
    end else if (in_fire && (op == OP_START)) begin
      layer_pos      <= '0;
      neuron_pos     <= '0;
      weight_ptr     <= '0;
      activation_ptr <= '0;
      running        <= (n_eff >= LCOUNT_W'(2));
    end else if (in_fire && (op == OP_TICK) && running && (n_eff < LCOUNT_W'(2))) begin
      running <= 1'b0;
    end else if (tick_go) begin
      weight_ptr <= wp_end;
      if (layer_end) begin
        activation_ptr <= activation_ptr + ACT_W'(cur_isz);
        if (finish) begin
          running    <= 1'b0;
          neuron_pos <= np_end;
        end else begin
          layer_pos  <= layer_pos + LIDX_W'(1);
          neuron_pos <= '0;
        end
      end else begin
        neuron_pos <= np_end;
      end
    end
  end

  // Result buffer payload, captured with each tick that dispatches (tick_go).
  always_ff @(posedge clk) begin
    if (tick_go) begin
      for (int u = 0; u < UNITS; u++) begin
        slot_np[u] <= slot_np_next[u];
        slot_wp[u] <= slot_wp_next[u];
      end
      res_isz  <= cur_isz;
      res_act  <= activation_ptr;
      res_done <= finish;
    end
  end

  // Pending slots: drained lowest first, refilled by a dispatching tick.
  assign pending_rest = pending & (pending - UNITS'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (tick_go) begin
      pending <= disp_mask;
    end else if (in_fire) begin
      pending <= '0;
    end else if (out_fire) begin
      pending <= pending_rest;
    end
  end

  // Lowest pending slot is the next item to leave.
  always_comb begin
    sel = '0;
    for (int u = UNITS - 1; u >= 0; u--) begin
      if (pending[u]) begin
        sel = SEL_W'(u);
      end
    end
  end

  // A new item is taken once the buffer is empty or its final item leaves now.
  assign in_ready = (pending == '0) || ((pending_rest == '0) && out_ready);

  assign out_valid         = (pending != '0);
  assign last              = (pending_rest == '0);
  assign unit              = UNIT_W'(sel);
  assign input_size        = res_isz;
  assign neuron_index      = slot_np[sel];
  assign weight_offset     = slot_wp[sel];
  assign activation_offset = res_act;
  assign done_res          = res_done && last;

endmodule

@@ hw/rtl/ljd_checker.sv @@
// Port-level checker for the layer neuron job dispatcher, bound to the top level.
module ljd_checker
  import ljd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_ready,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [UNIT_W-1:0]    unit,
  input  logic [SIZE_W-1:0]    input_size,
  input  logic [NEURON_W-1:0]  neuron_index,
  input  logic [WEIGHT_W-1:0]  weight_offset,
  input  logic [ACT_W-1:0]     activation_offset,
  input  logic                 done_res,
  input  logic                 last
);

  // A stalled result item holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(unit) && $stable(input_size) &&
      $stable(neuron_index) && $stable(weight_offset) && $stable(activation_offset) &&
      $stable(done_res) && $stable(last))
    else $error("stalled result item changed");

  // The final dispatch of a run is always the last item of its tick.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> last)
    else $error("done flagged on a non-final item");

  // New input is only taken when no result besides a departing final one waits.
  a_ready_drain: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid || (last && out_ready))
    else $error("input taken while results still pending");

  // Taking a result that is not the last leaves another one waiting.
  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("result items of a tick were lost");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind layer_neuron_job_dispatcher_top ljd_checker u_ljd_checker (.*);
